### src/lspg_pkg.sv
package lspg_pkg;

   // Strip limits; register values above these saturate
   localparam int MAX_LEDS       = 64;
   localparam int MAX_HALF_WIDTH = 32;

   // Bits of play_mode
   localparam int MODE_REPEAT_BIT  = 0;
   localparam int MODE_REVERSE_BIT = 1;

   typedef enum logic [2:0] {
      CSR_NUM_LEDS     = 3'd0,
      CSR_HALF_WIDTH   = 3'd1,
      CSR_SPEED        = 3'd2,
      CSR_HIGH_COLOR   = 3'd3,
      CSR_LOW_COLOR    = 3'd4,
      CSR_PLAY_MODE    = 3'd5,
      CSR_SHAPE_SELECT = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      SHAPE_LINEAR    = 2'd0,
      SHAPE_QUADRATIC = 2'd1,
      SHAPE_CUBIC     = 2'd2,
      SHAPE_FLAT      = 2'd3
   } shape_type;

   typedef struct packed {
      logic [6:0]  num_leds;
      logic [5:0]  half_width;
      logic [15:0] speed;
      logic [23:0] high_color;
      logic [23:0] low_color;
      logic [1:0]  play_mode;
      logic [1:0]  shape_select;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      num_leds:     7'd64,
      half_width:   6'd4,
      speed:        16'd2560,
      high_color:   24'hFFFFFF,
      low_color:    24'h000000,
      play_mode:    2'd1,
      shape_select: 2'd0
   };

   // One frame as handed from front to back
   typedef struct packed {
      logic              active;
      logic signed [7:0] n0;
   } frame_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL_PRE,
      F_CHECK,
      F_MUL_POST,
      F_FINISH,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_LED,
      B_CURVE,
      B_RATIO,
      B_NUM,
      B_DIV,
      B_EMIT
   } back_state_type;

   // Effective LED count, saturated
   function automatic logic [6:0] eff_leds(input cfg_type cfg);
      return (cfg.num_leds > 7'(MAX_LEDS)) ? 7'(MAX_LEDS) : cfg.num_leds;
   endfunction

   // Effective half width, saturated
   function automatic logic [5:0] eff_half(input cfg_type cfg);
      return (cfg.half_width > 6'(MAX_HALF_WIDTH)) ? 6'(MAX_HALF_WIDTH) : cfg.half_width;
   endfunction

endpackage

### src/lspg_front.sv
module lspg_front import lspg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_tick_time,
   input  logic        req_restart,
   output logic        push,
   output frame_type   push_data,
   input  logic        full
);

   front_state_type state_ff, state_in;
   logic [31:0]     et_ff, et_in;
   logic [15:0]     dt_ff, dt_in;
   logic [47:0]     prod_ff, prod_in;
   frame_type       frame_ff, frame_in;

   logic [6:0]  nl;
   logic [5:0]  h;
   logic [6:0]  w;
   logic [7:0]  lim;
   logic [47:0] prod_cur;
   logic [23:0] ip;
   logic        fr_nz;
   logic        pos_lt;
   logic        pos_gt;
   logic [32:0] sum;
   logic        wrap;
   logic [23:0] ipw;
   logic        frw;
   logic signed [25:0] ips, ws, nls, base, n0_ltr, n0_rtl, n0;
   logic        act;

   // Derive strip geometry and the pulse position tests
   always_comb begin
      nl       = eff_leds(cfg);
      h        = eff_half(cfg);
      w        = {h, 1'b0};
      lim      = {1'b0, nl} + {1'b0, w};
      prod_cur = et_ff * cfg.speed;
      ip       = prod_ff[47:24];
      fr_nz    = |prod_ff[23:0];
      pos_lt   = ip < {16'b0, lim};
      pos_gt   = (ip > {16'b0, lim}) || ((ip == {16'b0, lim}) && fr_nz);
      sum      = {1'b0, et_ff} + {17'b0, dt_ff};
      wrap     = cfg.play_mode[MODE_REPEAT_BIT] && pos_gt;
      ipw      = wrap ? 24'd0 : ip;
      frw      = wrap ? 1'b0 : fr_nz;
      ips      = $signed({2'b00, ipw});
      ws       = $signed({19'b0, w});
      nls      = $signed({19'b0, nl});
      // Start LED, truncated toward zero
      n0_ltr   = ips - ws + (((ipw < {17'b0, w}) && frw) ? 26'sd1 : 26'sd0);
      base     = nls - 26'sd1 - ips;
      n0_rtl   = base - ((frw && (base > 26'sd0)) ? 26'sd1 : 26'sd0);
      n0       = cfg.play_mode[MODE_REVERSE_BIT] ? n0_rtl : n0_ltr;
      act      = !(((n0 + ws) < 26'sd0) || (n0 >= nls));
   end

   // Sequence one tick transaction: check, advance, locate, hand off
   always_comb begin
      state_in  = state_ff;
      et_in     = et_ff;
      dt_in     = dt_ff;
      prod_in   = prod_ff;
      frame_in  = frame_ff;
      push      = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         F_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dt_in = req_tick_time;
               if (req_restart) begin
                  et_in = 32'd0;
               end
               state_in = F_MUL_PRE;
            end
         end
         F_MUL_PRE: begin
            prod_in  = prod_cur;
            state_in = F_CHECK;
         end
         F_CHECK: begin
            if (pos_lt) begin
               et_in    = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
               state_in = F_MUL_POST;
            end else begin
               frame_in.active = 1'b0;
               frame_in.n0     = 8'sd0;
               state_in        = F_PUSH;
            end
         end
         F_MUL_POST: begin
            prod_in  = prod_cur;
            state_in = F_FINISH;
         end
         F_FINISH: begin
            if (wrap) begin
               et_in = 32'd0;
            end
            frame_in.active = act;
            frame_in.n0     = n0[7:0];
            state_in        = F_PUSH;
         end
         F_PUSH: begin
            // Drop the frame when the strip is empty
            if (nl == 7'd0) begin
               state_in = F_IDLE;
            end else if (!full) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign push_data = frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         et_ff    <= 32'hFFFF_FFFF;
      end else begin
         state_ff <= state_in;
         et_ff    <= et_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff    <= dt_in;
      prod_ff  <= prod_in;
      frame_ff <= frame_in;
   end

endmodule

### src/lspg_queue.sv
module lspg_queue import lspg_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type push_data,
   output logic      full,
   input  logic      pop,
   output frame_type pop_data,
   output logic      empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   frame_type       mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed frame
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("frame pushed into a full queue");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("frame popped from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue occupancy beyond depth");

endmodule

### src/lspg_back.sv
module lspg_back import lspg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        empty,
   input  frame_type   head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_led_index,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_last
);

   back_state_type    state_ff, state_in;
   logic [5:0]        n_ff, n_in;
   logic signed [7:0] n0_ff, n0_in;
   logic              active_ff, active_in;
   logic [5:0]        a_ff, a_in;
   logic [10:0]       aa_ff, aa_in;
   logic [10:0]       hh_ff, hh_in;
   logic [6:0]        t2_ff, t2_in;
   logic [6:0]        t3_ff, t3_in;
   logic [15:0]       yn_ff, yn_in;
   logic [15:0]       yd_ff, yd_in;
   logic [23:0]       rem_ff [3];
   logic [23:0]       rem_in [3];
   logic [7:0]        q_ff [3];
   logic [7:0]        q_in [3];
   logic [1:0]        div_cnt_ff, div_cnt_in;
   logic [7:0]        color_ff [3];
   logic [7:0]        color_in [3];
   logic              rsp_valid_ff, rsp_valid_in;
   logic [5:0]        rsp_led_index_ff, rsp_led_index_in;
   logic [7:0]        rsp_red_ff, rsp_red_in;
   logic [7:0]        rsp_green_ff, rsp_green_in;
   logic [7:0]        rsp_blue_ff, rsp_blue_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [6:0]        nl;
   logic [5:0]        h;
   logic [6:0]        w;
   logic [5:0]        nl_m1;
   logic signed [8:0] k;
   logic [6:0]        kk;
   logic              in_win;
   logic [5:0]        a_next;
   logic              free;
   logic [7:0]        lo_ch [3];
   logic [7:0]        hi_ch [3];
   logic [2:0]        sh_hi, sh_lo;
   logic [23:0]       d_hi, d_lo;
   logic [23:0]       rem_mid [3];
   logic [23:0]       rem_step [3];
   logic [7:0]        q_step [3];
   logic              bit_hi [3];
   logic              bit_lo [3];
   logic [15:0]       yc;

   assign lo_ch[0] = cfg.low_color[23:16];
   assign lo_ch[1] = cfg.low_color[15:8];
   assign lo_ch[2] = cfg.low_color[7:0];
   assign hi_ch[0] = cfg.high_color[23:16];
   assign hi_ch[1] = cfg.high_color[15:8];
   assign hi_ch[2] = cfg.high_color[7:0];

   // Place the current LED against the pulse window
   always_comb begin
      nl     = eff_leds(cfg);
      h      = eff_half(cfg);
      w      = {h, 1'b0};
      nl_m1  = 6'(nl - 7'd1);
      k      = $signed({3'b000, n_ff}) - $signed({n0_ff[7], n0_ff});
      kk     = k[6:0];
      in_win = active_ff && (cfg.shape_select != SHAPE_FLAT) && !k[8]
               && (k < $signed({2'b00, w}));
      a_next = (kk < {1'b0, h}) ? 6'(kk + 7'd1) : 6'(w - 7'd1 - kk);
      free   = !rsp_valid_ff || rsp_ready;
      yc     = yd_ff - yn_ff;
   end

   // Two quotient bits per cycle for all three channels
   always_comb begin
      sh_hi = {~div_cnt_ff, 1'b1};
      sh_lo = {~div_cnt_ff, 1'b0};
      d_hi  = {8'b0, yd_ff} << sh_hi;
      d_lo  = {8'b0, yd_ff} << sh_lo;
      for (int c = 0; c < 3; c++) begin
         bit_hi[c]   = rem_ff[c] >= d_hi;
         rem_mid[c]  = bit_hi[c] ? rem_ff[c] - d_hi : rem_ff[c];
         bit_lo[c]   = rem_mid[c] >= d_lo;
         rem_step[c] = bit_lo[c] ? rem_mid[c] - d_lo : rem_mid[c];
         q_step[c]   = q_ff[c] | ({7'b0, bit_hi[c]} << sh_hi)
                       | ({7'b0, bit_lo[c]} << sh_lo);
      end
   end

   // Walk the LEDs of one frame
   always_comb begin
      state_in         = state_ff;
      n_in             = n_ff;
      n0_in            = n0_ff;
      active_in        = active_ff;
      a_in             = a_ff;
      aa_in            = aa_ff;
      hh_in            = hh_ff;
      t2_in            = t2_ff;
      t3_in            = t3_ff;
      yn_in            = yn_ff;
      yd_in            = yd_ff;
      rem_in           = rem_ff;
      q_in             = q_ff;
      div_cnt_in       = div_cnt_ff;
      color_in         = color_ff;
      pop              = 1'b0;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_led_index_in = rsp_led_index_ff;
      rsp_red_in       = rsp_red_ff;
      rsp_green_in     = rsp_green_ff;
      rsp_blue_in      = rsp_blue_ff;
      rsp_last_in      = rsp_last_ff;
      case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               pop       = 1'b1;
               n_in      = 6'd0;
               n0_in     = head.n0;
               active_in = head.active;
               state_in  = B_LED;
            end
         end
         B_LED: begin
            if (in_win) begin
               a_in     = a_next;
               state_in = B_CURVE;
            end else begin
               color_in = lo_ch;
               state_in = B_EMIT;
            end
         end
         B_CURVE: begin
            aa_in    = {5'b0, a_ff} * {5'b0, a_ff};
            hh_in    = {5'b0, h} * {5'b0, h};
            t2_in    = w - {1'b0, a_ff};
            t3_in    = {1'b0, h} + w - {a_ff, 1'b0};
            state_in = B_RATIO;
         end
         B_RATIO: begin
            case (cfg.shape_select)
               SHAPE_LINEAR: begin
                  yn_in = {10'b0, a_ff};
                  yd_in = {10'b0, h};
               end
               SHAPE_QUADRATIC: begin
                  yn_in = {9'b0, t2_ff} * {10'b0, a_ff};
                  yd_in = {5'b0, hh_ff};
               end
               SHAPE_CUBIC: begin
                  yn_in = {5'b0, aa_ff} * {9'b0, t3_ff};
                  yd_in = {5'b0, hh_ff} * {10'b0, h};
               end
               default: begin
                  yn_in = 16'd0;
                  yd_in = 16'd1;
               end
            endcase
            state_in = B_NUM;
         end
         B_NUM: begin
            // Weighted sum of both colors, divided by yd afterwards
            for (int c = 0; c < 3; c++) begin
               rem_in[c] = ({16'b0, lo_ch[c]} * {8'b0, yc})
                           + ({16'b0, hi_ch[c]} * {8'b0, yn_ff});
               q_in[c]   = 8'd0;
            end
            div_cnt_in = 2'd0;
            state_in   = B_DIV;
         end
         B_DIV: begin
            rem_in     = rem_step;
            q_in       = q_step;
            div_cnt_in = div_cnt_ff + 2'd1;
            if (div_cnt_ff == 2'd3) begin
               color_in = q_step;
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            // Load the output register once the receiver has room
            if (free) begin
               rsp_valid_in     = 1'b1;
               rsp_led_index_in = n_ff;
               rsp_red_in       = color_ff[0];
               rsp_green_in     = color_ff[1];
               rsp_blue_in      = color_ff[2];
               rsp_last_in      = (n_ff == nl_m1);
               if (n_ff == nl_m1) begin
                  state_in = B_IDLE;
               end else begin
                  n_in     = n_ff + 6'd1;
                  state_in = B_LED;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff             <= n_in;
      n0_ff            <= n0_in;
      active_ff        <= active_in;
      a_ff             <= a_in;
      aa_ff            <= aa_in;
      hh_ff            <= hh_in;
      t2_ff            <= t2_in;
      t3_ff            <= t3_in;
      yn_ff            <= yn_in;
      yd_ff            <= yd_in;
      rem_ff           <= rem_in;
      q_ff             <= q_in;
      div_cnt_ff       <= div_cnt_in;
      color_ff         <= color_in;
      rsp_led_index_ff <= rsp_led_index_in;
      rsp_red_ff       <= rsp_red_in;
      rsp_green_ff     <= rsp_green_in;
      rsp_blue_ff      <= rsp_blue_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_index = rsp_led_index_ff;
   assign rsp_red       = rsp_red_ff;
   assign rsp_green     = rsp_green_ff;
   assign rsp_blue      = rsp_blue_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

### src/led_strip_pulse_generator.sv
// Traveling pulse generator for an LED strip of up to 64 LEDs.
// req_ channel: one transaction per frame tick, carrying the tick duration
// (seconds, Q0.16) and a restart flag that starts the pulse from time zero.
// rsp_ channel: for every tick, one transaction per LED in index order,
// with its 8-bit red, green and blue and a last flag on the final LED.
// csr_ channel: register writes (index, data), always ready; write only
// while no frame is in flight.
// Each tick passes the front end's states in order: accept, multiply,
// check the pulse position, and, while the pulse is still on the strip,
// advance time, multiply again and locate the start LED; the frame is
// then pushed into the queue. The back end pops a frame and per LED tests
// the pulse window; an LED inside it goes through the curve multiplies,
// the shape ratio and the 2-bit-per-cycle color divider before it is
// emitted. The front end takes a new tick only once it has pushed the last
// frame, as long as the frame queue between front and back has room.
// Reset: registers take their defaults and the pulse is idle (all LEDs
// show the background color) until a tick with restart arrives.
// A stalled receiver holds the current LED in the output register; the
// back end waits, then the queue fills, then req_ready drops.
module led_strip_pulse_generator import lspg_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_tick_time,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_led_index,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   cfg_type   cfg_ff, cfg_in;
   logic      push;
   frame_type push_data;
   logic      full;
   logic      pop;
   frame_type pop_data;
   logic      empty;

   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_NUM_LEDS:     cfg_in.num_leds     = csr_data[6:0];
            CSR_HALF_WIDTH:   cfg_in.half_width   = csr_data[5:0];
            CSR_SPEED:        cfg_in.speed        = csr_data[15:0];
            CSR_HIGH_COLOR:   cfg_in.high_color   = csr_data[23:0];
            CSR_LOW_COLOR:    cfg_in.low_color    = csr_data[23:0];
            CSR_PLAY_MODE:    cfg_in.play_mode    = csr_data[1:0];
            CSR_SHAPE_SELECT: cfg_in.shape_select = csr_data[1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lspg_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_tick_time (req_tick_time),
      .req_restart   (req_restart),
      .push          (push),
      .push_data     (push_data),
      .full          (full)
   );

   lspg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   lspg_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .empty         (empty),
      .head          (pop_data),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_led_index (rsp_led_index),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_last      (rsp_last)
   );

endmodule
